// ----- sv/printf_integer_formatter_defines.svh -----
// assertion macros for the integer formatter
// no dependencies
`ifndef PRINTF_INTEGER_FORMATTER_DEFINES_SVH
`define PRINTF_INTEGER_FORMATTER_DEFINES_SVH
// assert that a condition implies a consequence on the same edge
`define PIF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: check failed");
// assert that a condition implies a consequence on the next edge
`define PIF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");
`endif

// ----- sv/pif_pkg.sv -----
// package for the integer formatter: word types, codes and digit_char
// no dependencies
`timescale 1ns / 1ps
package pif_pkg;

  typedef enum logic [2:0] {
    KIND_SDEC = 3'd0,
    KIND_UDEC = 3'd1,
    KIND_OCT  = 3'd2,
    KIND_HEXL = 3'd3,
    KIND_HEXU = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    SIZE_CHAR  = 3'd0,
    SIZE_SHORT = 3'd1,
    SIZE_INT   = 3'd2,
    SIZE_LONG  = 3'd3,
    SIZE_LLONG = 3'd4
  } size_e;

  localparam int unsigned DigW = 5;  // up to 22 octal digits
  localparam logic [6:0] ChSpace = 7'h20;
  localparam logic [6:0] ChZero  = 7'h30;
  localparam logic [6:0] ChMinus = 7'h2d;
  localparam logic [6:0] ChPlus  = 7'h2b;

  typedef struct packed {
    logic [63:0] raw_value;
    logic [2:0]  conv_kind;
    logic [2:0]  size_class;
    logic        width_given;
    logic [6:0]  field_width;
    logic        precision_given;
    logic [5:0]  precision;
    logic        left_justify;
    logic        zero_pad;
    logic        force_plus;
    logic        space_sign;
    logic        alt_form;
  } in_word_t;

  typedef struct packed {
    logic [6:0] char_out;
    logic       is_last;
  } out_word_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic mag_zero;
    logic bad_kind;
    logic last_char;
    logic empty;
  } dp_sts_t;

  function automatic logic [6:0] digit_char(input logic [3:0] d, input logic upper);
    logic [6:0] c;
    if (d < 4'd10) c = ChZero + {3'd0, d};
    else if (upper) c = 7'h37 + {3'd0, d};
    else c = 7'h57 + {3'd0, d};
    return c;
  endfunction

endpackage

// ----- sv/pif_ctrl.sv -----
// controller for the integer formatter: load, digit extraction, emission
// depends on pif_pkg
`timescale 1ns / 1ps
module pif_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  pif_pkg::dp_sts_t sts_i,
  output pif_pkg::dp_cmd_t cmd_o,
  output logic             busy_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_EMIT
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE: if (start_i) state_q <= ST_DIV;
        ST_DIV: if (sts_i.bad_kind) state_q <= ST_IDLE;
          else if (sts_i.mag_zero) state_q <= ST_CHECK;
        ST_CHECK: if (sts_i.empty) state_q <= ST_IDLE;
          else state_q <= ST_EMIT;
        ST_EMIT: if (sts_i.last_char) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o.load = (state_q == ST_IDLE) && start_i;
    cmd_o.step = (state_q == ST_DIV) && !sts_i.mag_zero;
    cmd_o.emit = (state_q == ST_EMIT);
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

// ----- sv/pif_dp.sv -----
// datapath for the integer formatter: magnitude, digit store, field layout
// depends on pif_pkg
`timescale 1ns / 1ps
module pif_dp #(
  parameter int unsigned MaxField = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pif_pkg::in_word_t in_i,
  input  pif_pkg::dp_cmd_t  cmd_i,
  output pif_pkg::dp_sts_t  sts_o,
  output pif_pkg::out_word_t word_o,
  output logic              valid_o
);

  localparam int unsigned CntW = $clog2(MaxField + 1);
  localparam int unsigned LayW = (CntW > 8) ? CntW : 8;
  localparam int unsigned NDig = 22;

  logic [63:0]      mag_q;
  logic [3:0]       dig_q [NDig];
  logic [pif_pkg::DigW-1:0] ndig_q;
  logic [1:0]       sub_q;
  logic [3:0]       r_q;
  logic [2:0]       kind_q;
  logic             alt_q, left_q, zpad_q, wgiven_q, pgiven_q;
  logic [6:0]       width_q;
  logic [5:0]       prec_q;
  logic [6:0]       pre0_q, pre1_q;
  logic [1:0]       npre_q;
  logic [CntW-1:0]  pos_q, total_q, padl_q, prel_q, zl_q;
  logic             valid_q;
  pif_pkg::out_word_t word_q;

  // load-time truncation and sign handling
  logic [63:0] mask, v, vneg;
  logic        neg, is_sdec;
  always_comb begin
    unique case (in_i.size_class)
      pif_pkg::SIZE_CHAR:  mask = 64'hff;
      pif_pkg::SIZE_SHORT: mask = 64'hffff;
      pif_pkg::SIZE_INT:   mask = 64'hffff_ffff;
      default:             mask = '1;
    endcase
    v = in_i.raw_value & mask;
    unique case (in_i.size_class)
      pif_pkg::SIZE_CHAR:  neg = v[7];
      pif_pkg::SIZE_SHORT: neg = v[15];
      pif_pkg::SIZE_INT:   neg = v[31];
      default:             neg = v[63];
    endcase
    is_sdec = (in_i.conv_kind == pif_pkg::KIND_SDEC);
    vneg = ((~v) + 64'd1) & mask;
  end

  // octal and hex: one digit per cycle
  // decimal: long division by 10 over four 16-bit chunks, one chunk per cycle
  logic        dec;
  logic [63:0] quo;
  logic [3:0]  rem;
  logic [19:0] x10;
  logic [39:0] prod;
  logic [15:0] qd;
  logic [18:0] back10;
  logic [3:0]  rd;
  always_comb begin
    dec = (kind_q == pif_pkg::KIND_SDEC) || (kind_q == pif_pkg::KIND_UDEC);
    x10 = {r_q, mag_q[63:48]};
    prod = {20'd0, x10} * 40'd838861;
    qd = prod[38:23];
    back10 = {qd, 3'b000} + {2'b00, qd, 1'b0};
    rd = x10[3:0] - back10[3:0];
    quo = mag_q;
    rem = '0;
    unique case (kind_q)
      pif_pkg::KIND_OCT: begin
        quo = mag_q >> 3;
        rem = {1'b0, mag_q[2:0]};
      end
      pif_pkg::KIND_HEXL, pif_pkg::KIND_HEXU: begin
        quo = mag_q >> 4;
        rem = mag_q[3:0];
      end
      default: ;
    endcase
  end

  // layout from digit count
  logic [LayW-1:0] prec_e, nz0, nz1, content, wid, pad, zl, padl, tot;
  always_comb begin
    prec_e = pgiven_q ? LayW'(prec_q) : LayW'(1);
    if (prec_e > LayW'(MaxField - 2)) prec_e = LayW'(MaxField - 2);
    nz0 = (prec_e > LayW'(ndig_q)) ? prec_e - LayW'(ndig_q) : '0;
    nz1 = (alt_q && kind_q == pif_pkg::KIND_OCT && nz0 == '0) ? LayW'(1) : nz0;
    wid = wgiven_q ? LayW'(width_q) : '0;
    if (wid > LayW'(MaxField)) wid = LayW'(MaxField);
    content = LayW'(npre_q) + nz1 + LayW'(ndig_q);
    pad = (wid > content) ? wid - content : '0;
    if (zpad_q && !left_q) begin
      zl = nz1 + pad;
      padl = '0;
    end else begin
      zl = nz1;
      padl = pad;
    end
    tot = content + pad;
  end

  // character selection by position
  logic [CntW-1:0] p_dig;
  logic [6:0]      ch;
  logic [CntW-1:0] p_idx;
  always_comb begin
    p_dig = pos_q - prel_q - zl_q;
    p_idx = CntW'(ndig_q) - CntW'(1) - p_dig;
    if (!left_q && pos_q < padl_q) ch = pif_pkg::ChSpace;
    else if (pos_q < padl_q + CntW'(npre_q)) ch = ((pos_q - padl_q) == '0) ? pre0_q : pre1_q;
    else if (pos_q < prel_q + zl_q) ch = pif_pkg::ChZero;
    else if (p_dig < CntW'(ndig_q))
      ch = pif_pkg::digit_char(dig_q[p_idx[pif_pkg::DigW-1:0]], kind_q == pif_pkg::KIND_HEXU);
    else ch = pif_pkg::ChSpace;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pos_q <= '0;
    end else begin
      valid_q <= cmd_i.emit;
      if (cmd_i.load) pos_q <= '0;
      else if (cmd_i.emit) pos_q <= pos_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q <= (is_sdec && neg) ? vneg : v;
      ndig_q <= '0;
      sub_q <= 2'd0;
      r_q <= 4'd0;
      kind_q <= in_i.conv_kind;
      alt_q <= in_i.alt_form;
      left_q <= in_i.left_justify;
      zpad_q <= in_i.zero_pad;
      wgiven_q <= in_i.width_given;
      width_q <= in_i.field_width;
      pgiven_q <= in_i.precision_given;
      prec_q <= in_i.precision;
      npre_q <= 2'd0;
      pre0_q <= pif_pkg::ChSpace;
      pre1_q <= pif_pkg::ChSpace;
      if (is_sdec) begin
        if (neg) begin
          npre_q <= 2'd1; pre0_q <= pif_pkg::ChMinus;
        end else if (in_i.force_plus) begin
          npre_q <= 2'd1; pre0_q <= pif_pkg::ChPlus;
        end else if (in_i.space_sign) begin
          npre_q <= 2'd1; pre0_q <= pif_pkg::ChSpace;
        end
      end else if (in_i.alt_form && v != 64'd0 &&
                   (in_i.conv_kind == pif_pkg::KIND_HEXL ||
                    in_i.conv_kind == pif_pkg::KIND_HEXU)) begin
        npre_q <= 2'd2;
        pre0_q <= pif_pkg::ChZero;
        pre1_q <= (in_i.conv_kind == pif_pkg::KIND_HEXU) ? 7'h58 : 7'h78;
      end
    end else if (cmd_i.step) begin
      if (dec) begin
        mag_q <= {mag_q[47:0], qd};
        sub_q <= sub_q + 2'd1;
        r_q <= (sub_q == 2'd3) ? 4'd0 : rd;
        if (sub_q == 2'd3) begin
          dig_q[ndig_q] <= rd;
          ndig_q <= ndig_q + pif_pkg::DigW'(1);
        end
      end else begin
        mag_q <= quo;
        dig_q[ndig_q] <= rem;
        ndig_q <= ndig_q + pif_pkg::DigW'(1);
      end
    end
    if (!cmd_i.load && !cmd_i.step && !cmd_i.emit) begin
      padl_q <= CntW'(left_q ? LayW'(0) : padl);
      prel_q <= CntW'(left_q ? LayW'(0) : padl) + CntW'(npre_q);
      zl_q <= CntW'(zl);
      total_q <= CntW'(tot);
    end
    word_q.char_out <= ch;
    word_q.is_last <= (pos_q + CntW'(1) == total_q);
  end

  // zero test only between decimal digits
  assign sts_o.mag_zero = (mag_q == 64'd0) && (sub_q == 2'd0);
  assign sts_o.bad_kind = (kind_q > pif_pkg::KIND_HEXU);
  assign sts_o.empty = (tot == '0);
  assign sts_o.last_char = (pos_q + CntW'(1) == total_q);
  assign word_o = word_q;
  assign valid_o = valid_q;

endmodule

// ----- sv/printf_integer_formatter.sv -----
// integer formatter: one request in, up to MAX_FIELD characters out
// octal and hex digits come one per cycle, decimal ones by long division by 10,
// then a zero test and a layout step, then one word per cycle
// busy spans digit extraction, zero test, layout and every character out
// reset returns the controller to idle; results cannot be stalled
// next request is taken once busy falls
`timescale 1ns / 1ps
`include "printf_integer_formatter_defines.svh"
module printf_integer_formatter #(
  parameter int unsigned MAX_FIELD = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  pif_pkg::in_word_t  in_word_i,
  output logic               strobe_o,
  output pif_pkg::out_word_t out_word_o
);

  pif_pkg::dp_cmd_t cmd;
  pif_pkg::dp_sts_t sts;

  pif_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  pif_dp #(.MaxField(MAX_FIELD)) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_word_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .word_o (out_word_o),
    .valid_o(strobe_o)
  );

  `PIF_ASSERT_NXT(a_emit_strobe, cmd.emit, strobe_o)
  `PIF_ASSERT_IMP(a_no_load_busy, busy, !cmd.load)
  `PIF_ASSERT_IMP(a_one_cmd, 1'b1, $onehot0({cmd.load, cmd.step, cmd.emit}))

endmodule
